### hw/rtl/hk_tsp_pkg.sv
// Shared types and constants for the Held-Karp tour solver.
// No dependencies.
package hk_tsp_pkg;
    localparam int MAX_CITIES = 12;
    localparam int DIST_BITS  = 16;
    localparam int CITY_W     = 4;
    localparam int COST_W     = 21;
    localparam int TOUR_W     = 20;
    localparam int SUBSETS    = 1 << MAX_CITIES;
    localparam int DIST_DEPTH = MAX_CITIES * MAX_CITIES;
    localparam int COST_DEPTH = SUBSETS * MAX_CITIES;
    localparam int DADDR_W    = $clog2(DIST_DEPTH);
    localparam int CADDR_W    = $clog2(COST_DEPTH);
    localparam int CIDX_W     = $clog2(MAX_CITIES);
    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
    localparam logic [TOUR_W-1:0] TOUR_MAX = {TOUR_W{1'b1}};

    typedef enum logic [3:0] {
        ST_LOAD, ST_CLEAR, ST_SEED, ST_RD_HERE, ST_WT_HERE, ST_RD_V, ST_WT_V,
        ST_WRITE, ST_FIN_RD, ST_FIN_WT, ST_FIN_CMP, ST_OUT
    } state_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [DIST_BITS-1:0] b);
        logic [COST_W:0] s;
        begin
            s = {1'b0, a} + (COST_W+1)'(b);
            if (a == COST_INF || s[COST_W] || s[COST_W-1:0] == COST_INF)
                sat_add = COST_INF;
            else
                sat_add = s[COST_W-1:0];
        end
    endfunction
endpackage

### hw/rtl/held_karp_tsp_solver_core.sv
// Top level of the Held-Karp tour solver: loader, sequencer, cost memories.
// Depends on hk_tsp_pkg and hk_tsp_ram.
//
// Usage:
//   s_axis carries distance-matrix words, one per cycle while s_axis_tready
//   is high. A word with tlast high stores its entry and starts a solve over
//   the first city_count cities (cfg channel, reset 12). tready stays low
//   from then until the result word is taken on m_axis.
//   Solve: a clear pass sets all 2^n * 12 cost-memory entries to infinity and
//   one seed write follows; then per subset each city inside it with a finite
//   cost is extended to every city outside it by a read, an add and a
//   compare-write, while cities outside the subset or with infinite cost are
//   skipped; then the closing edges back to city 0 are compared. The single
//   read port of the cost memory keeps these steps one after another.
//   With city_count below 2 the result word is valid the cycle after the
//   tlast word, no_tour=1.
//   m_axis holds its word until taken; a stalled receiver simply delays
//   the next load. Reset returns to loading with city_count = 12; the
//   distance memory is not cleared.
module held_karp_tsp_solver_core
    import hk_tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,        // city_count[3:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // from_city[3:0], to_city[7:4], distance[23:8]
    input  logic        s_axis_tlast,    // last_entry
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // tour_cost[19:0]
    output logic        m_axis_tuser     // no_tour
);
    state_t state_reg, state_next;
    logic [CITY_W-1:0] ncity_reg, ncity_next, cfg_n_reg;
    logic [MAX_CITIES-1:0] mask_reg, mask_next;
    logic [CITY_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [CADDR_W-1:0] clr_reg, clr_next;
    logic [COST_W-1:0] here_reg, here_next, best_reg, best_next, cand_reg, cand_next;
    logic [TOUR_W-1:0] cost_reg, cost_next;
    logic none_reg, none_next;
    logic [MAX_CITIES-1:0] full;

    logic d_we;
    logic [DADDR_W-1:0] d_waddr, d_raddr;
    logic [DIST_BITS-1:0] d_rdata;
    logic c_we;
    logic [CADDR_W-1:0] c_waddr, c_raddr;
    logic [COST_W-1:0] c_wdata, c_rdata;

    logic [CITY_W-1:0] in_from, in_to;
    logic s_fire;

    assign in_from = s_axis_tdata[3:0];
    assign in_to   = s_axis_tdata[7:4];
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign full    = MAX_CITIES'((1 << ncity_reg) - 1);

    function automatic logic [CADDR_W-1:0] caddr(input logic [MAX_CITIES-1:0] m,
                                                 input logic [CITY_W-1:0] c);
        caddr = CADDR_W'(m * MAX_CITIES) + CADDR_W'(c);
    endfunction

    function automatic logic [DADDR_W-1:0] daddr(input logic [CITY_W-1:0] r,
                                                 input logic [CITY_W-1:0] c);
        daddr = DADDR_W'(r * MAX_CITIES) + DADDR_W'(c);
    endfunction

    hk_tsp_ram #(.WIDTH(DIST_BITS), .DEPTH(DIST_DEPTH)) u_dist (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(s_axis_tdata[8 +: DIST_BITS]),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    hk_tsp_ram #(.WIDTH(COST_W), .DEPTH(COST_DEPTH)) u_cost (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    assign cfg_ready     = (state_reg == ST_LOAD);
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {4'd0, cost_reg};
    assign m_axis_tuser  = none_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cfg_n_reg <= CITY_W'(MAX_CITIES);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                cfg_n_reg <= cfg_data[CITY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        ncity_reg <= ncity_next;
        mask_reg  <= mask_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        clr_reg   <= clr_next;
        here_reg  <= here_next;
        best_reg  <= best_next;
        cand_reg  <= cand_next;
        cost_reg  <= cost_next;
        none_reg  <= none_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ncity_next = ncity_reg;
        mask_next  = mask_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        clr_next   = clr_reg;
        here_next  = here_reg;
        best_next  = best_reg;
        cand_next  = cand_reg;
        cost_next  = cost_reg;
        none_next  = none_reg;
        d_we       = 1'b0;
        d_waddr    = daddr(in_from, in_to);
        d_raddr    = daddr(u_reg, v_reg);
        c_we       = 1'b0;
        c_waddr    = caddr(mask_reg | MAX_CITIES'(1 << v_reg), v_reg);
        c_wdata    = cand_reg;
        c_raddr    = caddr(mask_reg | MAX_CITIES'(1 << v_reg), v_reg);
        case (state_reg)
            ST_LOAD:
            begin
                if (s_fire)
                begin
                    d_we = (32'(in_from) < MAX_CITIES) && (32'(in_to) < MAX_CITIES);
                    if (s_axis_tlast)
                    begin
                        ncity_next = (32'(cfg_n_reg) > MAX_CITIES) ? CITY_W'(MAX_CITIES)
                                                                  : cfg_n_reg;
                        clr_next = '0;
                        if (cfg_n_reg < 2)
                        begin
                            none_next  = 1'b1;
                            cost_next  = '0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            none_next  = 1'b0;
                            state_next = ST_CLEAR;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = clr_reg;
                c_wdata = COST_INF;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == caddr(full, CITY_W'(MAX_CITIES - 1)))
                    state_next = ST_SEED;
            end
            ST_SEED:
            begin
                c_we      = 1'b1;
                c_waddr   = caddr(MAX_CITIES'(1), '0);
                c_wdata   = '0;
                mask_next = MAX_CITIES'(1);
                u_next    = '0;
                state_next = ST_RD_HERE;
            end
            ST_RD_HERE:
            begin
                if (!mask_reg[u_reg[CIDX_W-1:0]])
                begin
                    if (u_reg == ncity_reg - 1'b1)
                    begin
                        u_next = '0;
                        if (mask_reg == full)
                        begin
                            v_next = CITY_W'(1);
                            best_next = COST_INF;
                            state_next = ST_FIN_RD;
                        end
                        else
                            mask_next = mask_reg + 1'b1;
                    end
                    else
                        u_next = u_reg + 1'b1;
                end
                else
                begin
                    c_raddr = caddr(mask_reg, u_reg);
                    v_next  = '0;
                    state_next = ST_WT_HERE;
                end
            end
            ST_WT_HERE:
            begin
                here_next = c_rdata;
                state_next = (c_rdata == COST_INF) ? ST_WRITE : ST_RD_V;
                if (c_rdata == COST_INF)
                    v_next = ncity_reg;
            end
            ST_RD_V:
            begin
                if (v_reg == ncity_reg)
                    state_next = ST_WRITE;
                else if (mask_reg[v_reg[CIDX_W-1:0]])
                    v_next = v_reg + 1'b1;
                else
                    state_next = ST_WT_V;
            end
            ST_WT_V:
            begin
                cand_next = sat_add(here_reg, d_rdata);
                state_next = ST_WRITE;
                // v_reg < ncity_reg here; WRITE performs compare
            end
            ST_WRITE:
            begin
                if (v_reg == ncity_reg)
                begin
                    if (u_reg == ncity_reg - 1'b1)
                    begin
                        u_next = '0;
                        if (mask_reg == full)
                        begin
                            v_next = CITY_W'(1);
                            best_next = COST_INF;
                            state_next = ST_FIN_RD;
                        end
                        else
                        begin
                            mask_next = mask_reg + 1'b1;
                            state_next = ST_RD_HERE;
                        end
                    end
                    else
                    begin
                        u_next = u_reg + 1'b1;
                        state_next = ST_RD_HERE;
                    end
                end
                else
                begin
                    c_we = cand_reg < c_rdata;
                    v_next = v_reg + 1'b1;
                    state_next = ST_RD_V;
                end
            end
            ST_FIN_RD:
            begin
                c_raddr = caddr(full, v_reg);
                d_raddr = daddr(v_reg, '0);
                state_next = ST_FIN_WT;
            end
            ST_FIN_WT:
            begin
                cand_next = sat_add(c_rdata, d_rdata);
                state_next = ST_FIN_CMP;
            end
            ST_FIN_CMP:
            begin
                if (cand_reg < best_reg)
                    best_next = cand_reg;
                if (v_reg == ncity_reg - 1'b1)
                begin
                    if ((cand_reg < best_reg ? cand_reg : best_reg) > COST_W'(TOUR_MAX))
                        cost_next = TOUR_MAX;
                    else
                        cost_next = TOUR_W'(cand_reg < best_reg ? cand_reg : best_reg);
                    state_next = ST_OUT;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                    state_next = ST_FIN_RD;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("loader ready during solve");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=> (state_reg == ST_CLEAR || state_reg == ST_OUT))
        else $error("solve not started");
endmodule

### hw/rtl/hk_tsp_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module hk_tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
